@@ design/oopu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oopu_pkg
// Shared types, constants and arithmetic helpers for the orbital object
// position updater.
// ----------------------------------------------------------------------------
package oopu_pkg;

	localparam int ObjectCount   = 64;
	localparam int TrigTableBits = 10;
	localparam int SlotW         = 6;
	localparam int CountW        = 7;

	localparam logic signed [15:0] SinA = 16'sd25736;
	localparam logic signed [15:0] SinB = 16'sd10584;
	localparam logic signed [15:0] SinC = 16'sd1232;

	// Parameter word selects.
	localparam logic [3:0] SEL_BASE_X  = 4'd0;
	localparam logic [3:0] SEL_BASE_Y  = 4'd1;
	localparam logic [3:0] SEL_BASE_Z  = 4'd2;
	localparam logic [3:0] SEL_VEL_X   = 4'd3;
	localparam logic [3:0] SEL_VEL_Y   = 4'd4;
	localparam logic [3:0] SEL_VEL_Z   = 4'd5;
	localparam logic [3:0] SEL_RADIUS  = 4'd6;
	localparam logic [3:0] SEL_RATE    = 4'd7;
	localparam logic [3:0] SEL_PHASE   = 4'd8;
	localparam logic [3:0] SEL_RIGHT   = 4'd9;
	localparam logic [3:0] SEL_FORWARD = 4'd10;
	localparam logic [3:0] SEL_GAIN    = 4'd11;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Datapath operation steps issued by the controller.
	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_READ   = 4'd1;
	localparam logic [3:0] OP_PHASE  = 4'd2;
	localparam logic [3:0] OP_SIN1   = 4'd3;
	localparam logic [3:0] OP_SIN2   = 4'd4;
	localparam logic [3:0] OP_SIN3   = 4'd5;
	localparam logic [3:0] OP_SIN4   = 4'd6;
	localparam logic [3:0] OP_BASIS  = 4'd7;
	localparam logic [3:0] OP_RADIUS = 4'd8;
	localparam logic [3:0] OP_DRIFT  = 4'd9;
	localparam logic [3:0] OP_SUM    = 4'd10;
	localparam logic [3:0] OP_EMIT   = 4'd11;

	typedef struct packed {
		logic [3:0]       op;
		logic [SlotW-1:0] slot;
		logic             last;
	} oopu_cmd_t;

	// Saturate a 36-bit sum to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [35:0] hi;
		logic signed [35:0] lo;
		begin
			hi = 36'sh07FFFFFFF;
			lo = -36'sh080000000;
			if (v > hi) sat32 = 32'sh7FFFFFFF;
			else if (v < lo) sat32 = 32'sh80000000;
			else sat32 = v[31:0];
		end
	endfunction

	// Select one basis component, a Q2.8 value already widened to Q2.14.
	function automatic logic signed [15:0] basis_comp(input logic [47:0] b,
			input int c);
		begin
			basis_comp = b[16*c +: 16];
		end
	endfunction

	function automatic logic [47:0] pack_basis(input logic [31:0] w);
		begin
			pack_basis = {w[29:20], 6'd0, w[19:10], 6'd0, w[9:0], 6'd0};
		end
	endfunction

endpackage

@@ design/oopu_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oopu_ctrl
// Sequencer that walks the active objects of a tick through the datapath
// steps, one step per cycle.
// ----------------------------------------------------------------------------
module oopu_ctrl
	import oopu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_go,
	input  logic [CountW-1:0] count,
	output logic              busy,
	output oopu_cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;

	logic [1:0]       state_q;
	logic [3:0]       op_q;
	logic [SlotW-1:0] slot_q;
	logic [CountW-1:0] n_q;
	logic [CountW-1:0] n_sat;

	assign n_sat = (count > CountW'(ObjectCount)) ? CountW'(ObjectCount) : count;

	// Step through the operations of each object, then the next object.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_NONE;
			slot_q  <= '0;
			n_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (tick_go && n_sat != '0) begin
						state_q <= ST_RUN;
						op_q    <= OP_READ;
						slot_q  <= '0;
						n_q     <= n_sat;
					end
				end
				ST_RUN: begin
					if (op_q == OP_EMIT) begin
						if ({1'b0, slot_q} + 7'd1 == n_q) begin
							state_q <= ST_IDLE;
							op_q    <= OP_NONE;
						end else begin
							slot_q <= slot_q + 6'd1;
							op_q   <= OP_READ;
						end
					end else begin
						op_q <= op_q + 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cmd.op    = (state_q == ST_RUN) ? op_q : OP_NONE;
	assign cmd.slot  = slot_q;
	assign cmd.last  = ({1'b0, slot_q} + 7'd1 == n_q);

endmodule

@@ design/oopu_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oopu_datapath
// Object parameter memories, drift memories and the shared arithmetic that
// computes one object position per pass.
// ----------------------------------------------------------------------------
module oopu_datapath
	import oopu_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [SlotW-1:0]        wr_slot,
	input  logic [3:0]              wr_sel,
	input  logic [31:0]             wr_value,
	input  logic                    tick_go,
	input  logic [15:0]             tick_seconds,
	input  logic signed [31:0]      viewer_x,
	input  logic signed [31:0]      viewer_z,
	input  oopu_cmd_t               cmd,
	output logic                    done,
	output logic [SlotW-1:0]        out_slot,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z,
	output logic                    last_of_tick
);

	// Parameter memories.
	logic signed [31:0] base_x_mem [ObjectCount];
	logic signed [31:0] base_y_mem [ObjectCount];
	logic signed [31:0] base_z_mem [ObjectCount];
	logic signed [31:0] vel_x_mem [ObjectCount];
	logic signed [31:0] vel_y_mem [ObjectCount];
	logic signed [31:0] vel_z_mem [ObjectCount];
	logic signed [31:0] radius_mem [ObjectCount];
	logic signed [31:0] rate_mem [ObjectCount];
	logic [15:0]        phase_mem [ObjectCount];
	logic [47:0]        right_mem [ObjectCount];
	logic [47:0]        fwd_mem [ObjectCount];
	logic [15:0]        gain_mem [ObjectCount];
	logic signed [31:0] drift_x_mem [ObjectCount];
	logic signed [31:0] drift_y_mem [ObjectCount];
	logic signed [31:0] drift_z_mem [ObjectCount];
	logic [ObjectCount-1:0] drift_vld_q;

	// Tick operands.
	logic [15:0]        dt_q;
	logic signed [31:0] vx_q;
	logic signed [31:0] vz_q;

	// Per-object working registers.
	logic signed [31:0] bx_q, by_q, bz_q, velx_q, vely_q, velz_q;
	logic signed [31:0] rad_q, rate_q, dx_q, dy_q, dz_q;
	logic [15:0]        ph_q, gain_q;
	logic [47:0]        rb_q, fb_q;
	logic [15:0]        q_q;
	logic signed [15:0] z_q [2];
	logic signed [31:0] z2_q [2];
	logic signed [31:0] t_q [2];
	logic signed [31:0] sin_q, cos_q;
	logic signed [31:0] m_q [3];
	logic signed [35:0] off_q [3];
	logic signed [31:0] ndx_q, ndy_q, ndz_q;
	logic signed [31:0] parx_q;
	logic signed [33:0] parz_q;
	logic [SlotW-1:0]   slot_q;
	logic               last_q;
	logic               done_q;
	logic signed [31:0] px_q, py_q, pz_q;

	logic [15:0] qmask;
	assign qmask = 16'(((32'hFFFF >> (16 - TrigTableBits)) << (16 - TrigTableBits)));

	// Parameter writes, and write-back of the advanced phase.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (wr_sel)
				SEL_BASE_X:  base_x_mem[wr_slot] <= wr_value;
				SEL_BASE_Y:  base_y_mem[wr_slot] <= wr_value;
				SEL_BASE_Z:  base_z_mem[wr_slot] <= wr_value;
				SEL_VEL_X:   vel_x_mem[wr_slot] <= wr_value;
				SEL_VEL_Y:   vel_y_mem[wr_slot] <= wr_value;
				SEL_VEL_Z:   vel_z_mem[wr_slot] <= wr_value;
				SEL_RADIUS:  radius_mem[wr_slot] <= wr_value;
				SEL_RATE:    rate_mem[wr_slot] <= wr_value;
				SEL_GAIN:    gain_mem[wr_slot] <= wr_value[15:0];
				SEL_RIGHT:   right_mem[wr_slot] <= pack_basis(wr_value);
				SEL_FORWARD: fwd_mem[wr_slot] <= pack_basis(wr_value);
				default: ;
			endcase
		end
		if (wr_en && wr_sel == SEL_PHASE)
			phase_mem[wr_slot] <= wr_value[15:0];
		else if (cmd.op == OP_SIN1 && rad_q > 0)
			phase_mem[slot_q] <= ph_q;
	end

	// Drift memories, with valid bits standing in for the reset clear.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_SUM) begin
			drift_x_mem[slot_q] <= ndx_q;
			drift_y_mem[slot_q] <= ndy_q;
			drift_z_mem[slot_q] <= ndz_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drift_vld_q <= '0;
		end else if (cmd.op == OP_SUM) begin
			drift_vld_q[slot_q] <= 1'b1;
		end
	end

	// Quarter-wave polynomial pieces for both sine and cosine.
	function automatic logic signed [15:0] quad_z(input logic [15:0] p);
		logic [14:0] r;
		begin
			r = {1'b0, p[13:0]};
			if (p[14]) r = 15'd16384 - r;
			quad_z = {1'b0, r};
		end
	endfunction

	logic [15:0] qc;
	assign qc = q_q + 16'd16384;

	always_ff @(posedge clk) begin
		if (tick_go) begin
			dt_q <= tick_seconds;
			vx_q <= viewer_x;
			vz_q <= viewer_z;
		end
		done_q <= 1'b0;
		case (cmd.op)
			OP_READ: begin
				slot_q <= cmd.slot;
				last_q <= cmd.last;
				bx_q   <= base_x_mem[cmd.slot];
				by_q   <= base_y_mem[cmd.slot];
				bz_q   <= base_z_mem[cmd.slot];
				velx_q <= vel_x_mem[cmd.slot];
				vely_q <= vel_y_mem[cmd.slot];
				velz_q <= vel_z_mem[cmd.slot];
				rad_q  <= radius_mem[cmd.slot];
				rate_q <= rate_mem[cmd.slot];
				ph_q   <= phase_mem[cmd.slot];
				rb_q   <= right_mem[cmd.slot];
				fb_q   <= fwd_mem[cmd.slot];
				gain_q <= gain_mem[cmd.slot];
				dx_q   <= drift_vld_q[cmd.slot] ? drift_x_mem[cmd.slot] : '0;
				dy_q   <= drift_vld_q[cmd.slot] ? drift_y_mem[cmd.slot] : '0;
				dz_q   <= drift_vld_q[cmd.slot] ? drift_z_mem[cmd.slot] : '0;
			end
			OP_PHASE: begin
				// Phase advance: floor(rate*dt/2^16) mod 2^16.
				logic signed [48:0] adv;
				adv = rate_q * $signed({1'b0, dt_q});
				if (rad_q > 0) ph_q <= ph_q + adv[31:16];
			end
			OP_SIN1: begin
				q_q    <= ph_q & qmask;
				parx_q <= 32'((49'(vx_q) * 49'($signed({1'b0, gain_q}))) >>> 16);
				parz_q <= 34'((49'(vz_q) * 49'($signed({1'b0, gain_q}))) >>> 15);
			end
			OP_SIN2: begin
				z_q[0]  <= quad_z(q_q);
				z_q[1]  <= quad_z(qc);
				z2_q[0] <= (32'(quad_z(q_q)) * 32'(quad_z(q_q))) >>> 14;
				z2_q[1] <= (32'(quad_z(qc)) * 32'(quad_z(qc))) >>> 14;
				ndx_q   <= sat32(36'(dx_q) +
					36'((48'(velx_q) * 48'($signed({1'b0, dt_q}))) >>> 16));
			end
			OP_SIN3: begin
				t_q[0] <= 32'(SinB) - ((z2_q[0] * 32'(SinC)) >>> 14);
				t_q[1] <= 32'(SinB) - ((z2_q[1] * 32'(SinC)) >>> 14);
				ndy_q  <= sat32(36'(dy_q) +
					36'((48'(vely_q) * 48'($signed({1'b0, dt_q}))) >>> 16));
			end
			OP_SIN4: begin
				t_q[0] <= 32'(SinA) - ((z2_q[0] * t_q[0]) >>> 14);
				t_q[1] <= 32'(SinA) - ((z2_q[1] * t_q[1]) >>> 14);
				ndz_q  <= sat32(36'(dz_q) +
					36'((48'(velz_q) * 48'($signed({1'b0, dt_q}))) >>> 16));
			end
			OP_BASIS: begin
				logic signed [31:0] sv, cv;
				sv = (32'(z_q[0]) * t_q[0]) >>> 14;
				cv = (32'(z_q[1]) * t_q[1]) >>> 14;
				sin_q <= q_q[15] ? -sv : sv;
				cos_q <= qc[15] ? -cv : cv;
			end
			OP_RADIUS: begin
				for (int c = 0; c < 3; c++)
					m_q[c] <= (32'(basis_comp(rb_q, c)) * cos_q
						+ 32'(basis_comp(fb_q, c)) * sin_q) >>> 14;
			end
			OP_DRIFT: begin
				for (int c = 0; c < 3; c++)
					off_q[c] <= (rad_q > 0) ? 36'((64'(m_q[c]) * 64'(rad_q)) >>> 14) : '0;
			end
			OP_SUM: begin
				px_q <= sat32(36'(bx_q) + off_q[0] + 36'(ndx_q) + 36'(parx_q));
				py_q <= sat32(36'(by_q) + off_q[1] + 36'(ndy_q));
				pz_q <= sat32(36'(bz_q) + off_q[2] + 36'(ndz_q) + 36'(parz_q));
			end
			OP_EMIT: done_q <= 1'b1;
			default: ;
		endcase
	end

	assign done         = done_q;
	assign out_slot     = slot_q;
	assign pos_x        = px_q;
	assign pos_y        = py_q;
	assign pos_z        = pz_q;
	assign last_of_tick = last_q;

endmodule

@@ design/orbital_object_position_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbital_object_position_update
// Object table that advances orbits and drift on each tick and emits one
// position per active object.
// ----------------------------------------------------------------------------
// Channel  | Handshake            | Payload
// input    | start / busy         | cmd, object_slot, word_select, word_value,
//          |                      | tick_seconds, viewer_x, viewer_z
// result   | done strobe          | out_slot, pos_x, pos_y, pos_z, last_of_tick
// config   | active_objects_we    | active_objects_wdata
//
// A write beat is taken while idle and leaves busy low.
// A tick walks each active object through the shared datapath step
// sequence, then busy falls; results leave one per object.
// Reset clears the count and the drift valid bits; no clearing pass.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module orbital_object_position_update
	import oopu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cmd,
	input  logic [5:0]         object_slot,
	input  logic [3:0]         word_select,
	input  logic [31:0]        word_value,
	input  logic [15:0]        tick_seconds,
	input  logic signed [31:0] viewer_x,
	input  logic signed [31:0] viewer_z,
	input  logic               active_objects_we,
	input  logic [6:0]         active_objects_wdata,
	output logic               done,
	output logic [5:0]         out_slot,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic               last_of_tick
);

	logic [CountW-1:0] count_q;
	logic              accept;
	logic              tick_go;
	logic              wr_en;
	oopu_cmd_t         dp_cmd;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (active_objects_we) begin
			count_q <= active_objects_wdata;
		end
	end

	assign accept  = start && !busy;
	assign tick_go = accept && cmd == CMD_TICK;
	assign wr_en   = accept && cmd == CMD_WRITE;

	oopu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.tick_go(tick_go),
		.count  (count_q),
		.busy   (busy),
		.cmd    (dp_cmd)
	);

	oopu_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_slot     (object_slot),
		.wr_sel      (word_select),
		.wr_value    (word_value),
		.tick_go     (tick_go),
		.tick_seconds(tick_seconds),
		.viewer_x    (viewer_x),
		.viewer_z    (viewer_z),
		.cmd         (dp_cmd),
		.done        (done),
		.out_slot    (out_slot),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.last_of_tick(last_of_tick)
	);

`ifndef ASSERT_OFF
	// A result beat only appears while a tick is in progress or just ended.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result outside a tick");
	// The block is already idle when the last result of a tick appears.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last_of_tick) |-> !busy) else $error("busy after last result");
	// A write never starts a tick.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_WRITE) |=> !busy) else $error("write set busy");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the orbital object position updater. It loads the
// object table, sends write and tick beats with random gaps, and predicts
// each emitted position with a fixed-point model of the orbit, drift and
// parallax math. The predicted positions are compared in order with the
// strobed results.
// ----------------------------------------------------------------------------
module tb_top;
	import oopu_pkg::*;

	localparam int WatchLimit = 4000;
	localparam int SettleCycles = 40;
	// Entries that are fully loaded and may be made active.
	localparam int LoadSlots = 16;

	typedef struct {
		logic [5:0]         slot;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               last;
	} position_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               cmd = CMD_WRITE;
	logic [5:0]         object_slot = '0;
	logic [3:0]         word_select = '0;
	logic [31:0]        word_value = '0;
	logic [15:0]        tick_seconds = '0;
	logic signed [31:0] viewer_x = '0;
	logic signed [31:0] viewer_z = '0;
	logic               active_objects_we = 1'b0;
	logic [6:0]         active_objects_wdata = '0;
	logic               done;
	logic [5:0]         out_slot;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic               last_of_tick;

	// Shadow copy of the object table and the active count.
	logic signed [31:0] base_mem [3][ObjectCount];
	logic signed [31:0] vel_mem [3][ObjectCount];
	logic signed [31:0] drift_mem [3][ObjectCount];
	logic signed [31:0] radius_mem [ObjectCount];
	logic signed [31:0] rate_mem [ObjectCount];
	logic [15:0]        phase_mem [ObjectCount];
	logic [47:0]        right_mem [ObjectCount];
	logic [47:0]        fwd_mem [ObjectCount];
	logic [15:0]        gain_mem [ObjectCount];
	logic [6:0]         count_shadow = '0;

	position_t pos_expected_q[$];
	int        error_count = 0;
	int        sender_idle_pct = 0;
	int        quiet_cycles = 0;

	orbital_object_position_update uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.object_slot(object_slot), .word_select(word_select),
		.word_value(word_value), .tick_seconds(tick_seconds),
		.viewer_x(viewer_x), .viewer_z(viewer_z),
		.active_objects_we(active_objects_we),
		.active_objects_wdata(active_objects_wdata),
		.done(done), .out_slot(out_slot), .pos_x(pos_x), .pos_y(pos_y),
		.pos_z(pos_z), .last_of_tick(last_of_tick)
	);

	always #10 clk = ~clk;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Polynomial sine in Q14 with quadrant mirroring.
	function automatic longint sine_q14(input logic [15:0] p);
		logic [1:0] quad;
		longint r, z2, t, t2, v;
		quad = p[15:14];
		r = p[13:0];
		if (quad[0]) r = 16384 - r;
		z2 = (r * r) >>> 14;
		t = longint'(SinB) - ((z2 * longint'(SinC)) >>> 14);
		t2 = longint'(SinA) - ((z2 * t) >>> 14);
		v = (r * t2) >>> 14;
		return quad[1] ? -v : v;
	endfunction

	function automatic logic [47:0] widen_basis(input logic [31:0] w);
		return {w[29:20], 6'd0, w[19:10], 6'd0, w[9:0], 6'd0};
	endfunction

	function automatic void store_word(input logic [5:0] s, input logic [3:0] sel,
			input logic [31:0] w);
		case (sel)
			SEL_BASE_X: base_mem[0][s] = w;
			SEL_BASE_Y: base_mem[1][s] = w;
			SEL_BASE_Z: base_mem[2][s] = w;
			SEL_VEL_X: vel_mem[0][s] = w;
			SEL_VEL_Y: vel_mem[1][s] = w;
			SEL_VEL_Z: vel_mem[2][s] = w;
			SEL_RADIUS: radius_mem[s] = w;
			SEL_RATE: rate_mem[s] = w;
			SEL_PHASE: phase_mem[s] = w[15:0];
			SEL_RIGHT: right_mem[s] = widen_basis(w);
			SEL_FORWARD: fwd_mem[s] = widen_basis(w);
			SEL_GAIN: gain_mem[s] = w[15:0];
			default: ;
		endcase
	endfunction

	// Advance every active object by one tick and queue its position.
	function automatic void advance_tick(input logic [15:0] ts,
			input logic signed [31:0] vxw, input logic signed [31:0] vzw);
		int n;
		longint dt, vx, vz, radius, adv, m, g;
		longint offs [3];
		longint s, co, p [3];
		logic [15:0] ph, q, qmask;
		logic signed [15:0] rc, fc;
		position_t e;
		dt = ts;
		vx = vxw;
		vz = vzw;
		n = (count_shadow > ObjectCount) ? ObjectCount : count_shadow;
		qmask = (16'hFFFF >> (16 - TrigTableBits)) << (16 - TrigTableBits);
		for (int i = 0; i < n; i++) begin
			offs = '{0, 0, 0};
			radius = radius_mem[i];
			if (radius > 0) begin
				adv = (longint'(rate_mem[i]) * dt) >>> 16;
				ph = phase_mem[i] + adv[15:0];
				q = ph & qmask;
				s = sine_q14(q);
				co = sine_q14(q + 16'd16384);
				phase_mem[i] = ph;
				for (int c = 0; c < 3; c++) begin
					rc = right_mem[i][16*c +: 16];
					fc = fwd_mem[i][16*c +: 16];
					m = longint'(rc) * co + longint'(fc) * s;
					offs[c] = ((m >>> 14) * radius) >>> 14;
				end
			end
			for (int c = 0; c < 3; c++) begin
				drift_mem[c][i] = 32'(clamp32(longint'(drift_mem[c][i]) +
					((longint'(vel_mem[c][i]) * dt) >>> 16)));
				p[c] = longint'(base_mem[c][i]) + offs[c] + longint'(drift_mem[c][i]);
			end
			g = gain_mem[i];
			p[0] = p[0] + ((vx * g) >>> 16);
			p[2] = p[2] + ((vz * g) >>> 15);
			e.slot = 6'(i);
			e.x = 32'(clamp32(p[0]));
			e.y = 32'(clamp32(p[1]));
			e.z = 32'(clamp32(p[2]));
			e.last = (i == n - 1);
			pos_expected_q.push_back(e);
		end
	endfunction

	// Drive one beat, wait for it to be taken, then maybe leave a gap.
	task automatic send_beat(input logic c, input logic [5:0] s, input logic [3:0] sel,
			input logic [31:0] w, input logic [15:0] ts, input logic [31:0] vx,
			input logic [31:0] vz);
		cmd <= c;
		object_slot <= s;
		word_select <= sel;
		word_value <= w;
		tick_seconds <= ts;
		viewer_x <= vx;
		viewer_z <= vz;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (c == CMD_TICK) advance_tick(ts, vx, vz);
		else store_word(s, sel, w);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic write_word(input logic [5:0] s, input logic [3:0] sel, input logic [31:0] w);
		send_beat(CMD_WRITE, s, sel, w, 16'($urandom), $urandom, $urandom);
	endtask

	task automatic tick(input logic [15:0] ts, input logic [31:0] vx, input logic [31:0] vz);
		send_beat(CMD_TICK, 6'($urandom), 4'($urandom), $urandom, ts, vx, vz);
	endtask

	// Let the block go idle and all expected results arrive.
	task automatic quiesce();
		start <= 1'b0;
		while (pos_expected_q.size() != 0 || busy) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_active(input logic [6:0] v);
		quiesce();
		active_objects_we <= 1'b1;
		active_objects_wdata <= v;
		@(posedge clk);
		active_objects_we <= 1'b0;
		count_shadow = v;
	endtask

	function automatic logic [31:0] pick_word(input logic [3:0] sel);
		case ($urandom_range(7))
			0: return $urandom;
			1: return ($urandom_range(1)) ? 32'h7FFFFFFF : 32'h80000000;
			default: begin
				if (sel == SEL_RATE) return $urandom_range(0, 32'h40000) - 32'h20000;
				return $urandom_range(0, 32'h200000) - 32'h100000;
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_viewer();
		case ($urandom_range(5))
			0: return $urandom;
			1: return ($urandom_range(1)) ? 32'h7FFFFFFF : 32'h80000000;
			default: return $urandom_range(0, 32'h2000000) - 32'h1000000;
		endcase
	endfunction

	// Every parameter word of every entry that can be active is written
	// before any tick.
	task automatic test_table_load();
		for (int s = 0; s < LoadSlots; s++)
			for (int sel = SEL_BASE_X; sel <= SEL_GAIN; sel++)
				write_word(6'(s), 4'(sel), pick_word(4'(sel)));
	endtask

	// Extremes, reserved words, zero count, flat orbits.
	task automatic test_directed();
		set_active(7'd1);
		write_word(6'd0, SEL_RADIUS, 32'h00010000);
		write_word(6'd0, SEL_RIGHT, 32'h3FFFFFFF);
		write_word(6'd0, SEL_FORWARD, 32'h20080200);
		write_word(6'd0, SEL_GAIN, 32'hFFFFFFFF);
		for (int sel = SEL_GAIN + 1; sel < 16; sel++) write_word(6'd0, 4'(sel), $urandom);
		tick(16'hFFFF, 32'h7FFFFFFF, 32'h80000000);
		tick(16'h0000, 32'h80000000, 32'h7FFFFFFF);
		write_word(6'd0, SEL_RADIUS, 32'h00000000);
		tick(16'h8000, 32'h00010000, 32'hFFFF0000);
		write_word(6'd0, SEL_RADIUS, 32'h80000000);
		write_word(6'd63, SEL_BASE_X, 32'h7FFFFFFF);
		write_word(6'd63, SEL_VEL_X, 32'h7FFFFFFF);
		tick(16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		set_active(7'd0);
		tick(16'h1234, pick_viewer(), pick_viewer());
		set_active(7'(LoadSlots));
		tick(16'h0001, 32'h00000000, 32'h00000000);
	endtask

	// Mostly writes with random content, ticks now and then.
	task automatic test_random(input int beats, input int idle_pct);
		sender_idle_pct = idle_pct;
		for (int k = 0; k < beats; k++) begin
			if ($urandom_range(99) < 20)
				tick(16'($urandom_range(3) == 0 ? $urandom : $urandom_range(0, 4096)),
					pick_viewer(), pick_viewer());
			else begin
				automatic logic [3:0] sel = 4'($urandom);
				write_word(6'($urandom_range(0, LoadSlots - 1)), sel, pick_word(sel));
			end
		end
	endtask

	// Result checker: each done beat against the oldest expectation.
	always @(posedge clk) begin
		if (done) begin
			if (pos_expected_q.size() == 0) begin
				$display("%0t: unexpected result slot=%0d x=%h y=%h z=%h last=%b",
					$time, out_slot, pos_x, pos_y, pos_z, last_of_tick);
				error_count++;
			end else begin
				automatic position_t e = pos_expected_q.pop_front();
				if (out_slot !== e.slot || pos_x !== e.x || pos_y !== e.y ||
						pos_z !== e.z || last_of_tick !== e.last) begin
					$display("%0t: mismatch expected slot=%0d x=%h y=%h z=%h last=%b",
						$time, e.slot, e.x, e.y, e.z, e.last);
					$display("%0t:          actual   slot=%0d x=%h y=%h z=%h last=%b",
						$time, out_slot, pos_x, pos_y, pos_z, last_of_tick);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no accepted beat and no result.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchLimit) begin
			$display("orbital_object_position_update test failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int s = 0; s < ObjectCount; s++)
			for (int c = 0; c < 3; c++) drift_mem[c][s] = 0;
		test_table_load();
		test_directed();
		test_random(30, 0);
		set_active(7'($urandom_range(2, LoadSlots)));
		test_random(30, 66);
		set_active(7'(LoadSlots));
		test_random(30, 25);
		set_active(7'($urandom_range(1, LoadSlots)));
		test_random(30, 0);
		quiesce();
		if (error_count == 0) $display("orbital_object_position_update test passed");
		else $display("orbital_object_position_update test failed");
		$finish;
	end

endmodule

@@ sim.f @@
design/oopu_pkg.sv
design/oopu_ctrl.sv
design/oopu_datapath.sv
design/orbital_object_position_update.sv
verif/tb_top.sv
